@@ src/wsfc_pkg.sv @@
// Shared constants for the wall segment frustum clipper.
// Used by the pipelined divider and by the top level; depends on nothing.
package wsfc_pkg;

    // Quotient width of every division and the latency of one divider.
    localparam int QUO_W   = 32;
    localparam int DIV_LAT = QUO_W + 2;

    // Width of a configuration register.
    localparam int CFG_W = 31;

    // Configuration register indexes.
    localparam logic [1:0] REG_NEAR_DEPTH      = 2'd0;
    localparam logic [1:0] REG_NEAR_HALF_WIDTH = 2'd1;
    localparam logic [1:0] REG_FAR_DEPTH       = 2'd2;
    localparam logic [1:0] REG_FAR_HALF_WIDTH  = 2'd3;

    // Configuration reset values, Q16.16.
    localparam logic [CFG_W-1:0] NEAR_DEPTH_RST      = 31'd65536;
    localparam logic [CFG_W-1:0] NEAR_HALF_WIDTH_RST = 31'd65536;
    localparam logic [CFG_W-1:0] FAR_DEPTH_RST       = 31'd327680000;
    localparam logic [CFG_W-1:0] FAR_HALF_WIDTH_RST  = 31'd1310720000;

    // Saturation limits of a quotient.
    localparam logic signed [QUO_W-1:0] QUO_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QUO_W-1:0] QUO_MIN = 32'sh8000_0000;

endpackage

@@ src/wsfc_div.sv @@
// Pipelined signed divider: quotient rounded toward zero, saturated to 32 bits.
// One restoring step per stage; depends on wsfc_pkg for widths and limits.
module wsfc_div #(
    parameter int NUM_W = 98,
    parameter int DEN_W = 66
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [NUM_W-1:0]             num,
    input  logic signed [DEN_W-1:0]             den,
    output logic signed [wsfc_pkg::QUO_W-1:0]   quo
);

    localparam int QW = wsfc_pkg::QUO_W;
    localparam int HW = NUM_W - QW;
    localparam int CW = ((HW > DEN_W) ? HW : DEN_W) + 1;

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;

    logic [DEN_W-1:0] rem_reg      [0:QW];
    logic [DEN_W-1:0] rem_next     [0:QW];
    logic [QW-1:0]    low_reg      [0:QW];
    logic [QW-1:0]    low_next     [0:QW];
    logic [QW-1:0]    part_reg     [0:QW];
    logic [QW-1:0]    part_next    [0:QW];
    logic [DEN_W-1:0] dmag_reg     [0:QW];
    logic [DEN_W-1:0] dmag_next    [0:QW];
    logic             neg_reg      [0:QW];
    logic             neg_next     [0:QW];
    logic             sat_reg      [0:QW];
    logic             sat_next     [0:QW];
    logic [DEN_W:0]   trial        [0:QW-1];
    logic             fits         [0:QW-1];

    logic [QW-1:0]          quo_last;
    logic signed [QW-1:0]   res_reg;
    logic signed [QW-1:0]   res_next;

    // Magnitudes, sign and the early test for a quotient of 2^32 or more.
    always_comb
    begin
        num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
        den_mag = den[DEN_W-1] ? (~den + 1'b1) : den;
        rem_next[0]  = DEN_W'(num_mag[NUM_W-1:QW]);
        low_next[0]  = num_mag[QW-1:0];
        part_next[0] = '0;
        dmag_next[0] = den_mag;
        neg_next[0]  = num[NUM_W-1] ^ den[DEN_W-1];
        sat_next[0]  = CW'(num_mag[NUM_W-1:QW]) >= CW'(den_mag);
        for (int k = 0; k < QW; k++)
        begin
            trial[k] = {rem_reg[k], low_reg[k][QW-1]};
            fits[k]  = trial[k] >= {1'b0, dmag_reg[k]};
            rem_next[k+1]  = fits[k] ? DEN_W'(trial[k] - {1'b0, dmag_reg[k]})
                                     : trial[k][DEN_W-1:0];
            low_next[k+1]  = {low_reg[k][QW-2:0], 1'b0};
            part_next[k+1] = {part_reg[k][QW-2:0], fits[k]};
            dmag_next[k+1] = dmag_reg[k];
            neg_next[k+1]  = neg_reg[k];
            sat_next[k+1]  = sat_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                low_reg[k]  <= low_next[k];
                part_reg[k] <= part_next[k];
                dmag_reg[k] <= dmag_next[k];
                neg_reg[k]  <= neg_next[k];
                sat_reg[k]  <= sat_next[k];
            end
            res_reg <= res_next;
        end
    end

    // Apply the sign and clamp to the signed 32-bit range.
    always_comb
    begin
        quo_last = part_reg[QW];
        if (sat_reg[QW])
            res_next = neg_reg[QW] ? wsfc_pkg::QUO_MIN : wsfc_pkg::QUO_MAX;
        else if (neg_reg[QW])
            res_next = (quo_last > {1'b1, {(QW-1){1'b0}}}) ? wsfc_pkg::QUO_MIN
                                                           : $signed(~quo_last + 1'b1);
        else
            res_next = quo_last[QW-1] ? wsfc_pkg::QUO_MAX : $signed(quo_last);
    end

    assign quo = res_reg;

endmodule

@@ src/wall_segment_frustum_clip.sv @@
// Top level of the wall segment frustum clipper.
// Depends on wsfc_pkg and on the pipelined divider wsfc_div.
//
// Clips one wall segment, given in view space as two signed Q16.16 endpoints,
// against the left and right edges of a 2D view frustum, and remaps the
// texture span onto the clipped ends. One request enters per clock cycle
// while seg_stall is low. Five stages form the cross products and the
// intersection numerators, a 34-stage divider bank gives the four
// intersection coordinates, four stages pick the clipped ends, the texture
// axis and its numerators, a second 34-stage divider pair gives the texture
// coordinates, and a final output register holds the result. The latency is
// set by the two restoring dividers, one quotient bit per stage. The pipeline
// keeps moving while the output waits, as long as its last stage is empty,
// so a stalled result does not stop new requests from entering until that
// stage fills. When a divisor that is needed is zero, div_fault is set and
// every other field is zero. Configuration registers are written through the
// plain write port; the user must write them only while no request is in
// flight, which the block itself does not enforce. Writes need no handshake.
module wall_segment_frustum_clip (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                seg_valid,
    output logic                seg_stall,
    input  logic signed [31:0]  start_x,
    input  logic signed [31:0]  start_depth,
    input  logic signed [31:0]  end_x,
    input  logic signed [31:0]  end_depth,
    input  logic [30:0]         tex_span,

    output logic                clip_valid,
    input  logic                clip_stall,
    output logic signed [31:0]  clip_start_x,
    output logic signed [31:0]  clip_start_depth,
    output logic signed [31:0]  clip_end_x,
    output logic signed [31:0]  clip_end_depth,
    output logic signed [31:0]  tex_start,
    output logic signed [31:0]  tex_end,
    output logic                div_fault,

    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [30:0]         cfg_data
);

    localparam int DL = wsfc_pkg::DIV_LAT;

    // Endpoint data that travels alongside the arithmetic.
    typedef struct packed {
        logic signed [31:0] x0;
        logic signed [31:0] y0;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic [30:0]        span;
        logic               clip0;
        logic               clip1;
        logic               fault;
    } seg_side_t;

    // Clipped ends that wait for the texture division.
    typedef struct packed {
        logic signed [31:0] ex0;
        logic signed [31:0] ey0;
        logic signed [31:0] ex1;
        logic signed [31:0] ey1;
        logic               fault;
    } clip_side_t;

    // ---------------------------------------------------------------------
    // Flow control. The output register loads when it is empty or its
    // request is taken; the rest of the pipeline also moves when its last
    // stage holds nothing, since no result can then be lost.
    // ---------------------------------------------------------------------
    logic pipe_en;
    logic out_load;
    logic tail_valid;
    logic clip_valid_reg;

    assign out_load  = !clip_valid_reg || !clip_stall;
    assign pipe_en   = out_load || !tail_valid;
    assign seg_stall = !pipe_en;

    // ---------------------------------------------------------------------
    // Configuration registers and the frustum terms derived from them.
    // ---------------------------------------------------------------------
    logic [30:0] near_depth_reg;
    logic [30:0] near_hw_reg;
    logic [30:0] far_depth_reg;
    logic [30:0] far_hw_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_depth_reg <= wsfc_pkg::NEAR_DEPTH_RST;
            near_hw_reg    <= wsfc_pkg::NEAR_HALF_WIDTH_RST;
            far_depth_reg  <= wsfc_pkg::FAR_DEPTH_RST;
            far_hw_reg     <= wsfc_pkg::FAR_HALF_WIDTH_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                wsfc_pkg::REG_NEAR_DEPTH:      near_depth_reg <= cfg_data;
                wsfc_pkg::REG_NEAR_HALF_WIDTH: near_hw_reg    <= cfg_data;
                wsfc_pkg::REG_FAR_DEPTH:       far_depth_reg  <= cfg_data;
                wsfc_pkg::REG_FAR_HALF_WIDTH:  far_hw_reg     <= cfg_data;
            endcase
        end
    end

    // The left edge runs through (-near_hw, near_depth) and (-far_hw,
    // far_depth). Its direction is (far_hw - near_hw, near_depth - far_depth)
    // and its cross term is far_hw*near_depth - near_hw*far_depth. The right
    // edge has the lateral direction and the cross term negated.
    logic signed [31:0] dxl_reg;
    logic signed [31:0] dy_reg;
    logic [61:0]        bfar_reg;
    logic [61:0]        bnear_reg;
    logic signed [62:0] b_reg;

    always_ff @(posedge clk)
    begin
        dxl_reg   <= $signed({1'b0, far_hw_reg}) - $signed({1'b0, near_hw_reg});
        dy_reg    <= $signed({1'b0, near_depth_reg}) - $signed({1'b0, far_depth_reg});
        bfar_reg  <= 62'(far_hw_reg) * 62'(near_depth_reg);
        bnear_reg <= 62'(near_hw_reg) * 62'(far_depth_reg);
        b_reg     <= $signed({1'b0, bfar_reg}) - $signed({1'b0, bnear_reg});
    end

    // ---------------------------------------------------------------------
    // Stage 1: differences of the endpoints and the halves of their cross
    // product, plus the near plane test of each endpoint.
    // ---------------------------------------------------------------------
    logic               s1_valid_reg;
    seg_side_t          s1_side_reg;
    logic signed [32:0] s1_dx_reg;
    logic signed [32:0] s1_dy_reg;
    logic signed [63:0] s1_pa_reg;
    logic signed [63:0] s1_pb_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s1_side_reg.x0    <= start_x;
            s1_side_reg.y0    <= start_depth;
            s1_side_reg.x1    <= end_x;
            s1_side_reg.y1    <= end_depth;
            s1_side_reg.span  <= tex_span;
            s1_side_reg.clip0 <= start_depth < $signed({1'b0, near_depth_reg});
            s1_side_reg.clip1 <= end_depth < $signed({1'b0, near_depth_reg});
            s1_side_reg.fault <= 1'b0;
            s1_dx_reg <= 33'(start_x) - 33'(end_x);
            s1_dy_reg <= 33'(start_depth) - 33'(end_depth);
            s1_pa_reg <= 64'(start_x) * 64'(end_depth);
            s1_pb_reg <= 64'(end_x) * 64'(start_depth);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: the segment cross term and the two halves of the divisors.
    // ---------------------------------------------------------------------
    logic               s2_valid_reg;
    seg_side_t          s2_side_reg;
    logic signed [32:0] s2_dx_reg;
    logic signed [32:0] s2_dy_reg;
    logic signed [64:0] s2_a_reg;
    logic signed [64:0] s2_m1_reg;
    logic signed [64:0] s2_m2_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s2_side_reg <= s1_side_reg;
            s2_dx_reg   <= s1_dx_reg;
            s2_dy_reg   <= s1_dy_reg;
            s2_a_reg    <= 65'(s1_pa_reg) - 65'(s1_pb_reg);
            s2_m1_reg   <= 65'(s1_dx_reg) * 65'(dy_reg);
            s2_m2_reg   <= 65'(s1_dy_reg) * 65'(dxl_reg);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: both divisors, and the numerator products cut into partial
    // products of about 33 by 33 bits.
    // ---------------------------------------------------------------------
    logic               s3_valid_reg;
    seg_side_t          s3_side_reg;
    logic signed [65:0] s3_denl_reg;
    logic signed [65:0] s3_denr_reg;
    logic signed [65:0] s3_pl_reg;
    logic signed [63:0] s3_ph_reg;
    logic signed [65:0] s3_rl_reg;
    logic signed [63:0] s3_rh_reg;
    logic signed [65:0] s3_ql_reg;
    logic signed [63:0] s3_qh_reg;
    logic signed [65:0] s3_sl_reg;
    logic signed [63:0] s3_sh_reg;
    logic signed [33:0] s3_alo;
    logic signed [31:0] s3_ahi;
    logic signed [32:0] s3_blo;
    logic signed [30:0] s3_bhi;

    assign s3_alo = $signed({1'b0, s2_a_reg[32:0]});
    assign s3_ahi = $signed(s2_a_reg[64:33]);
    assign s3_blo = $signed({1'b0, b_reg[31:0]});
    assign s3_bhi = $signed(b_reg[62:32]);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s3_side_reg <= s2_side_reg;
            s3_denl_reg <= 66'(s2_m1_reg) - 66'(s2_m2_reg);
            s3_denr_reg <= 66'(s2_m1_reg) + 66'(s2_m2_reg);
            s3_pl_reg   <= 66'(s3_alo) * 66'(dxl_reg);
            s3_ph_reg   <= 64'(s3_ahi) * 64'(dxl_reg);
            s3_rl_reg   <= 66'(s3_alo) * 66'(dy_reg);
            s3_rh_reg   <= 64'(s3_ahi) * 64'(dy_reg);
            s3_ql_reg   <= 66'(s2_dx_reg) * 66'(s3_blo);
            s3_qh_reg   <= 64'(s2_dx_reg) * 64'(s3_bhi);
            s3_sl_reg   <= 66'(s2_dy_reg) * 66'(s3_blo);
            s3_sh_reg   <= 64'(s2_dy_reg) * 64'(s3_bhi);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: the partial products are summed into four full products. A
    // clipped endpoint with a parallel frustum edge is a fault.
    // ---------------------------------------------------------------------
    logic               s4_valid_reg;
    seg_side_t          s4_side_reg;
    seg_side_t          s4_side_next;
    logic signed [65:0] s4_denl_reg;
    logic signed [65:0] s4_denr_reg;
    logic signed [96:0] s4_p_reg;
    logic signed [95:0] s4_q_reg;
    logic signed [96:0] s4_r_reg;
    logic signed [95:0] s4_s_reg;

    always_comb
    begin
        s4_side_next       = s3_side_reg;
        s4_side_next.fault = (s3_side_reg.clip0 || s3_side_reg.clip1)
                             && (s3_denl_reg == '0 || s3_denr_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s4_side_reg <= s4_side_next;
            s4_denl_reg <= s3_denl_reg;
            s4_denr_reg <= s3_denr_reg;
            s4_p_reg    <= $signed({s3_ph_reg, 33'd0}) + 97'(s3_pl_reg);
            s4_q_reg    <= $signed({s3_qh_reg, 32'd0}) + 96'(s3_ql_reg);
            s4_r_reg    <= $signed({s3_rh_reg, 33'd0}) + 97'(s3_rl_reg);
            s4_s_reg    <= $signed({s3_sh_reg, 32'd0}) + 96'(s3_sl_reg);
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: the four intersection numerators. The right edge gives the
    // lateral numerator negated and the depth numerator with the cross
    // term added instead of subtracted.
    // ---------------------------------------------------------------------
    logic               s5_valid_reg;
    seg_side_t          s5_side_reg;
    logic signed [65:0] s5_denl_reg;
    logic signed [65:0] s5_denr_reg;
    logic signed [97:0] s5_nlx_reg;
    logic signed [97:0] s5_nly_reg;
    logic signed [97:0] s5_nrx_reg;
    logic signed [97:0] s5_nry_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            s5_side_reg <= s4_side_reg;
            s5_denl_reg <= s4_denl_reg;
            s5_denr_reg <= s4_denr_reg;
            s5_nlx_reg  <= 98'(s4_p_reg) - 98'(s4_q_reg);
            s5_nrx_reg  <= 98'(s4_q_reg) - 98'(s4_p_reg);
            s5_nly_reg  <= 98'(s4_r_reg) - 98'(s4_s_reg);
            s5_nry_reg  <= 98'(s4_r_reg) + 98'(s4_s_reg);
        end
    end

    // ---------------------------------------------------------------------
    // Intersection dividers, with the endpoint data delayed to match.
    // ---------------------------------------------------------------------
    logic signed [31:0] lx;
    logic signed [31:0] ly;
    logic signed [31:0] rx;
    logic signed [31:0] ry;

    wsfc_div #(.NUM_W(98), .DEN_W(66)) u_div_lx (
        .clk(clk), .en(pipe_en), .num(s5_nlx_reg), .den(s5_denl_reg), .quo(lx)
    );
    wsfc_div #(.NUM_W(98), .DEN_W(66)) u_div_ly (
        .clk(clk), .en(pipe_en), .num(s5_nly_reg), .den(s5_denl_reg), .quo(ly)
    );
    wsfc_div #(.NUM_W(98), .DEN_W(66)) u_div_rx (
        .clk(clk), .en(pipe_en), .num(s5_nrx_reg), .den(s5_denr_reg), .quo(rx)
    );
    wsfc_div #(.NUM_W(98), .DEN_W(66)) u_div_ry (
        .clk(clk), .en(pipe_en), .num(s5_nry_reg), .den(s5_denr_reg), .quo(ry)
    );

    seg_side_t da_reg       [0:DL-1];
    logic      da_valid_reg [0:DL-1];

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            da_reg[0] <= s5_side_reg;
            for (int k = 1; k < DL; k++)
                da_reg[k] <= da_reg[k-1];
        end
    end

    // ---------------------------------------------------------------------
    // Stage T1: each clipped endpoint takes the left intersection when that
    // lies at positive depth, otherwise the right one.
    // ---------------------------------------------------------------------
    logic               t1_valid_reg;
    seg_side_t          t1_side_reg;
    logic signed [31:0] t1_ex0_reg;
    logic signed [31:0] t1_ey0_reg;
    logic signed [31:0] t1_ex1_reg;
    logic signed [31:0] t1_ey1_reg;
    logic               use_left;
    seg_side_t          da_last;

    assign da_last  = da_reg[DL-1];
    assign use_left = ly > 32'sd0;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            t1_side_reg <= da_last;
            t1_ex0_reg  <= da_last.clip0 ? (use_left ? lx : rx) : da_last.x0;
            t1_ey0_reg  <= da_last.clip0 ? (use_left ? ly : ry) : da_last.y0;
            t1_ex1_reg  <= da_last.clip1 ? (use_left ? lx : rx) : da_last.x1;
            t1_ey1_reg  <= da_last.clip1 ? (use_left ? ly : ry) : da_last.y1;
        end
    end

    // ---------------------------------------------------------------------
    // Stage T2: absolute extents of the clipped segment on both axes.
    // ---------------------------------------------------------------------
    logic               t2_valid_reg;
    seg_side_t          t2_side_reg;
    clip_side_t         t2_ends_reg;
    logic [32:0]        t2_dlat_reg;
    logic [32:0]        t2_ddep_reg;
    logic signed [32:0] t2_lat_diff;
    logic signed [32:0] t2_dep_diff;

    always_comb
    begin
        t2_lat_diff = 33'(t1_ex1_reg) - 33'(t1_ex0_reg);
        t2_dep_diff = 33'(t1_ey1_reg) - 33'(t1_ey0_reg);
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            t2_side_reg       <= t1_side_reg;
            t2_ends_reg.ex0   <= t1_ex0_reg;
            t2_ends_reg.ey0   <= t1_ey0_reg;
            t2_ends_reg.ex1   <= t1_ex1_reg;
            t2_ends_reg.ey1   <= t1_ey1_reg;
            t2_ends_reg.fault <= t1_side_reg.fault;
            t2_dlat_reg <= t2_lat_diff[32] ? ~t2_lat_diff + 1'b1 : t2_lat_diff;
            t2_ddep_reg <= t2_dep_diff[32] ? ~t2_dep_diff + 1'b1 : t2_dep_diff;
        end
    end

    // ---------------------------------------------------------------------
    // Stage T3: the dominant axis picks the offsets of the clipped ends from
    // the original start and the texture divisor.
    // ---------------------------------------------------------------------
    logic               t3_valid_reg;
    clip_side_t         t3_ends_reg;
    logic [30:0]        t3_span_reg;
    logic signed [32:0] t3_d0_reg;
    logic signed [32:0] t3_d1_reg;
    logic signed [32:0] t3_tden_reg;
    logic               lat_axis;

    assign lat_axis = t2_dlat_reg > t2_ddep_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            t3_ends_reg <= t2_ends_reg;
            t3_span_reg <= t2_side_reg.span;
            if (lat_axis)
            begin
                t3_d0_reg   <= 33'(t2_ends_reg.ex0) - 33'(t2_side_reg.x0);
                t3_d1_reg   <= 33'(t2_ends_reg.ex1) - 33'(t2_side_reg.x0);
                t3_tden_reg <= 33'(t2_side_reg.x1) - 33'(t2_side_reg.x0);
            end
            else
            begin
                t3_d0_reg   <= 33'(t2_ends_reg.ey0) - 33'(t2_side_reg.y0);
                t3_d1_reg   <= 33'(t2_ends_reg.ey1) - 33'(t2_side_reg.y0);
                t3_tden_reg <= 33'(t2_side_reg.y1) - 33'(t2_side_reg.y0);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage T4: texture numerators; a zero texture divisor is a fault.
    // ---------------------------------------------------------------------
    logic               t4_valid_reg;
    clip_side_t         t4_ends_reg;
    clip_side_t         t4_ends_next;
    logic signed [64:0] t4_n0_reg;
    logic signed [64:0] t4_n1_reg;
    logic signed [32:0] t4_tden_reg;
    logic signed [31:0] t4_span;

    assign t4_span = $signed({1'b0, t3_span_reg});

    always_comb
    begin
        t4_ends_next       = t3_ends_reg;
        t4_ends_next.fault = t3_ends_reg.fault || t3_tden_reg == '0;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            t4_ends_reg <= t4_ends_next;
            t4_n0_reg   <= 65'(t3_d0_reg) * 65'(t4_span);
            t4_n1_reg   <= 65'(t3_d1_reg) * 65'(t4_span);
            t4_tden_reg <= t3_tden_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Texture dividers, with the clipped ends delayed to match.
    // ---------------------------------------------------------------------
    logic signed [31:0] tq0;
    logic signed [31:0] tq1;

    wsfc_div #(.NUM_W(65), .DEN_W(33)) u_div_t0 (
        .clk(clk), .en(pipe_en), .num(t4_n0_reg), .den(t4_tden_reg), .quo(tq0)
    );
    wsfc_div #(.NUM_W(65), .DEN_W(33)) u_div_t1 (
        .clk(clk), .en(pipe_en), .num(t4_n1_reg), .den(t4_tden_reg), .quo(tq1)
    );

    clip_side_t db_reg       [0:DL-1];
    logic       db_valid_reg [0:DL-1];
    clip_side_t db_last;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            db_reg[0] <= t4_ends_reg;
            for (int k = 1; k < DL; k++)
                db_reg[k] <= db_reg[k-1];
        end
    end

    assign db_last    = db_reg[DL-1];
    assign tail_valid = db_valid_reg[DL-1];

    // ---------------------------------------------------------------------
    // Output register. A fault clears every field but the flag.
    // ---------------------------------------------------------------------
    logic signed [31:0] out_sx_reg;
    logic signed [31:0] out_sy_reg;
    logic signed [31:0] out_ex_reg;
    logic signed [31:0] out_ey_reg;
    logic signed [31:0] out_t0_reg;
    logic signed [31:0] out_t1_reg;
    logic               out_fault_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_fault_reg <= db_last.fault;
            if (db_last.fault)
            begin
                out_sx_reg <= '0;
                out_sy_reg <= '0;
                out_ex_reg <= '0;
                out_ey_reg <= '0;
                out_t0_reg <= '0;
                out_t1_reg <= '0;
            end
            else
            begin
                out_sx_reg <= db_last.ex0;
                out_sy_reg <= db_last.ey0;
                out_ex_reg <= db_last.ex1;
                out_ey_reg <= db_last.ey1;
                out_t0_reg <= tq0;
                out_t1_reg <= tq1;
            end
        end
    end

    assign clip_valid       = clip_valid_reg;
    assign clip_start_x     = out_sx_reg;
    assign clip_start_depth = out_sy_reg;
    assign clip_end_x       = out_ex_reg;
    assign clip_end_depth   = out_ey_reg;
    assign tex_start        = out_t0_reg;
    assign tex_end          = out_t1_reg;
    assign div_fault        = out_fault_reg;

    // ---------------------------------------------------------------------
    // Valid bits travel with the data through every stage.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            s4_valid_reg   <= 1'b0;
            s5_valid_reg   <= 1'b0;
            t1_valid_reg   <= 1'b0;
            t2_valid_reg   <= 1'b0;
            t3_valid_reg   <= 1'b0;
            t4_valid_reg   <= 1'b0;
            clip_valid_reg <= 1'b0;
            for (int k = 0; k < DL; k++)
            begin
                da_valid_reg[k] <= 1'b0;
                db_valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (pipe_en)
            begin
                s1_valid_reg    <= seg_valid;
                s2_valid_reg    <= s1_valid_reg;
                s3_valid_reg    <= s2_valid_reg;
                s4_valid_reg    <= s3_valid_reg;
                s5_valid_reg    <= s4_valid_reg;
                da_valid_reg[0] <= s5_valid_reg;
                for (int k = 1; k < DL; k++)
                    da_valid_reg[k] <= da_valid_reg[k-1];
                t1_valid_reg    <= da_valid_reg[DL-1];
                t2_valid_reg    <= t1_valid_reg;
                t3_valid_reg    <= t2_valid_reg;
                t4_valid_reg    <= t3_valid_reg;
                db_valid_reg[0] <= t4_valid_reg;
                for (int k = 1; k < DL; k++)
                    db_valid_reg[k] <= db_valid_reg[k-1];
            end
            if (out_load)
                clip_valid_reg <= tail_valid;
        end
    end

`ifndef SYNTHESIS
    // A faulted result carries no coordinates.
    a_fault_clears: assert property (@(posedge clk) disable iff (!rst_n)
        clip_valid && div_fault |-> clip_start_x == 0 && clip_start_depth == 0
            && clip_end_x == 0 && clip_end_depth == 0 && tex_start == 0 && tex_end == 0)
        else $error("faulted result has nonzero fields");

    // New requests are refused only while a result waits at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        seg_stall |-> clip_valid && clip_stall)
        else $error("input stalled without a waiting result");
`endif

endmodule

@@ bench/tb_wall_segment_frustum_clip.sv @@
// Self-checking testbench for the wall segment frustum clipper.
// Depends on wsfc_pkg and the wall_segment_frustum_clip top level; it carries its own
// exact 128-bit predictor of the clipped ends and texture coordinates.
module tb_wall_segment_frustum_clip;

    typedef bit bool_t;

    // One clipped result as it leaves the block.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sd;
        logic signed [31:0] ex;
        logic signed [31:0] ed;
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic               fault;
    } clip_t;

    // One request as it enters the block.
    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sd;
        logic signed [31:0] ex;
        logic signed [31:0] ed;
        logic [30:0]        span;
    } wall_t;

    logic               clk;
    logic               rst_n;
    logic               seg_valid;
    logic               seg_stall;
    logic signed [31:0] start_x;
    logic signed [31:0] start_depth;
    logic signed [31:0] end_x;
    logic signed [31:0] end_depth;
    logic [30:0]        tex_span;
    logic               clip_valid;
    logic               clip_stall;
    logic signed [31:0] clip_start_x;
    logic signed [31:0] clip_start_depth;
    logic signed [31:0] clip_end_x;
    logic signed [31:0] clip_end_depth;
    logic signed [31:0] tex_start;
    logic signed [31:0] tex_end;
    logic               div_fault;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;

    wall_segment_frustum_clip dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .seg_valid        (seg_valid),
        .seg_stall        (seg_stall),
        .start_x          (start_x),
        .start_depth      (start_depth),
        .end_x            (end_x),
        .end_depth        (end_depth),
        .tex_span         (tex_span),
        .clip_valid       (clip_valid),
        .clip_stall       (clip_stall),
        .clip_start_x     (clip_start_x),
        .clip_start_depth (clip_start_depth),
        .clip_end_x       (clip_end_x),
        .clip_end_depth   (clip_end_depth),
        .tex_start        (tex_start),
        .tex_end          (tex_end),
        .div_fault        (div_fault),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Pipeline depth of the top level, plus some margin for draining.
    localparam int LATENCY = 78;
    localparam int DRAIN   = LATENCY + 40;

    // The bench's own copy of the frustum registers.
    logic [30:0] frustum_near_depth;
    logic [30:0] frustum_near_half;
    logic [30:0] frustum_far_depth;
    logic [30:0] frustum_far_half;

    clip_t pending_clips[$];
    int    error_count;
    bool_t quiet_tail;

    // Directed stimulus row; has_known marks rows whose result is typed in.
    typedef struct {
        wall_t wall;
        bit    has_known;
        clip_t known;
    } wall_row_t;

    // Clock: period 20.
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Signed quotient rounded toward zero and saturated to 32 bits.
    function automatic logic signed [31:0] div_sat(logic signed [127:0] num,
                                                   logic signed [127:0] den);
        logic [127:0]        an;
        logic [127:0]        ad;
        logic [127:0]        q;
        logic                neg;
        neg = num[127] ^ den[127];
        an  = num[127] ? -num : num;
        ad  = den[127] ? -den : den;
        q   = an / ad;
        if (neg)
        begin
            if (q > 128'd2147483648)
                return wsfc_pkg::QUO_MIN;
            return -q[31:0];
        end
        if (q > 128'd2147483647)
            return wsfc_pkg::QUO_MAX;
        return q[31:0];
    endfunction

    // Intersection of the wall's line with one frustum edge line.
    // Returns zero when the two lines are parallel.
    function automatic bit edge_cross(logic signed [127:0] x1, logic signed [127:0] y1,
                                      logic signed [127:0] x2, logic signed [127:0] y2,
                                      logic signed [127:0] x3, logic signed [127:0] y3,
                                      logic signed [127:0] x4, logic signed [127:0] y4,
                                      output logic signed [31:0] ix,
                                      output logic signed [31:0] iy);
        logic signed [127:0] dx12;
        logic signed [127:0] dy12;
        logic signed [127:0] dx34;
        logic signed [127:0] dy34;
        logic signed [127:0] den;
        logic signed [127:0] a;
        logic signed [127:0] b;
        dx12 = x1 - x2;
        dy12 = y1 - y2;
        dx34 = x3 - x4;
        dy34 = y3 - y4;
        den  = dx12 * dy34 - dy12 * dx34;
        a    = x1 * y2 - x2 * y1;
        b    = x3 * y4 - x4 * y3;
        ix   = '0;
        iy   = '0;
        if (den == 0)
            return 1'b0;
        ix = div_sat(a * dx34 - dx12 * b, den);
        iy = div_sat(a * dy34 - dy12 * b, den);
        return 1'b1;
    endfunction

    // Predicts the clipped wall for one request under the current registers.
    function automatic clip_t predict_clip(wall_t w);
        clip_t               r;
        logic signed [127:0] nz;
        logic signed [127:0] ns;
        logic signed [127:0] fz;
        logic signed [127:0] fs;
        logic signed [31:0]  lx;
        logic signed [31:0]  ly;
        logic signed [31:0]  rx;
        logic signed [31:0]  ry;
        logic signed [127:0] e0x;
        logic signed [127:0] e0y;
        logic signed [127:0] e1x;
        logic signed [127:0] e1y;
        logic signed [127:0] dlat;
        logic signed [127:0] ddep;
        logic signed [127:0] base;
        logic signed [127:0] tden;
        logic signed [127:0] p0;
        logic signed [127:0] p1;
        logic signed [127:0] span;
        bit                  okl;
        bit                  okr;
        bit                  clip0;
        bit                  clip1;
        r    = '0;
        nz   = frustum_near_depth;
        ns   = frustum_near_half;
        fz   = frustum_far_depth;
        fs   = frustum_far_half;
        span = w.span;
        okl  = edge_cross(w.sx, w.sd, w.ex, w.ed, -ns, nz, -fs, fz, lx, ly);
        okr  = edge_cross(w.sx, w.sd, w.ex, w.ed, ns, nz, fs, fz, rx, ry);
        clip0 = 128'(w.sd) < nz;
        clip1 = 128'(w.ed) < nz;
        if ((clip0 || clip1) && !(okl && okr))
        begin
            r.fault = 1'b1;
            return r;
        end
        e0x = w.sx;
        e0y = w.sd;
        e1x = w.ex;
        e1y = w.ed;
        // Replace each near endpoint with the left crossing when it lies ahead, else the right one.
        if (clip0)
        begin
            e0x = (ly > 0) ? lx : rx;
            e0y = (ly > 0) ? ly : ry;
        end
        if (clip1)
        begin
            e1x = (ly > 0) ? lx : rx;
            e1y = (ly > 0) ? ly : ry;
        end
        dlat = e1x - e0x;
        if (dlat < 0)
            dlat = -dlat;
        ddep = e1y - e0y;
        if (ddep < 0)
            ddep = -ddep;
        if (dlat > ddep)
        begin
            base = w.sx;
            tden = 128'(w.ex) - 128'(w.sx);
            p0   = e0x;
            p1   = e1x;
        end
        else
        begin
            base = w.sd;
            tden = 128'(w.ed) - 128'(w.sd);
            p0   = e0y;
            p1   = e1y;
        end
        if (tden == 0)
        begin
            r.fault = 1'b1;
            return r;
        end
        r.sx = e0x[31:0];
        r.sd = e0y[31:0];
        r.ex = e1x[31:0];
        r.ed = e1y[31:0];
        r.t0 = div_sat((p0 - base) * span, tden);
        r.t1 = div_sat((p1 - base) * span, tden);
        return r;
    endfunction

    // Writes one frustum register at the falling edge and mirrors it.
    task automatic write_frustum(logic [1:0] idx, logic [30:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            wsfc_pkg::REG_NEAR_DEPTH:      frustum_near_depth = value;
            wsfc_pkg::REG_NEAR_HALF_WIDTH: frustum_near_half  = value;
            wsfc_pkg::REG_FAR_DEPTH:       frustum_far_depth  = value;
            wsfc_pkg::REG_FAR_HALF_WIDTH:  frustum_far_half   = value;
            default:                       ;
        endcase
        repeat (3) @(negedge clk);
    endtask

    task automatic set_frustum(logic [30:0] nd, logic [30:0] nh,
                               logic [30:0] fd, logic [30:0] fh);
        write_frustum(wsfc_pkg::REG_NEAR_DEPTH, nd);
        write_frustum(wsfc_pkg::REG_NEAR_HALF_WIDTH, nh);
        write_frustum(wsfc_pkg::REG_FAR_DEPTH, fd);
        write_frustum(wsfc_pkg::REG_FAR_HALF_WIDTH, fh);
    endtask

    // Waits until every expected result has come and the pipeline is empty.
    task automatic drain_pipeline();
        while (pending_clips.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    // Presents one request, with an optional idle burst first, and waits for
    // it to be taken. Valid stays high between back-to-back requests.
    task automatic send_wall(wall_t w, bit has_known, clip_t known);
        clip_t expected_clip;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            seg_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        seg_valid   <= 1'b1;
        start_x     <= w.sx;
        start_depth <= w.sd;
        end_x       <= w.ex;
        end_depth   <= w.ed;
        tex_span    <= w.span;
        expected_clip = has_known ? known : predict_clip(w);
        @(posedge clk);
        while (seg_stall)
            @(posedge clk);
        pending_clips.push_back(expected_clip);
        @(negedge clk);
    endtask

    // Random coordinate: mostly moderate values, sometimes the full range.
    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
            2:       return $signed($urandom_range(0, 32'h0000_FFFF));
            default: return $signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000;
        endcase
    endfunction

    function automatic wall_t rand_wall();
        wall_t w;
        w.sx = rand_coord();
        w.sd = rand_coord();
        w.ex = rand_coord();
        w.ed = rand_coord();
        // Occasionally share a coordinate so that a texture divisor may be zero.
        if ($urandom_range(0, 15) == 0)
            w.ed = w.sd;
        if ($urandom_range(0, 15) == 0)
            w.ex = w.sx;
        w.span = ($urandom_range(0, 7) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h00FF_FFFF));
        return w;
    endfunction

    // Receiver: random stall bursts, then none once the tail begins.
    initial
    begin
        clip_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                clip_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            clip_stall <= 1'b0;
        end
    end

    // Checker: compares every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && clip_valid && !clip_stall)
        begin
            clip_t got;
            clip_t want;
            got = '{clip_start_x, clip_start_depth, clip_end_x, clip_end_depth,
                    tex_start, tex_end, div_fault};
            if (pending_clips.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                error_count++;
            end
            else
            begin
                want = pending_clips.pop_front();
                if (got.sx !== want.sx)
                    $display("%0t: clip_start_x exp %0d got %0d", $time, want.sx, got.sx);
                if (got.sd !== want.sd)
                    $display("%0t: clip_start_depth exp %0d got %0d", $time, want.sd, got.sd);
                if (got.ex !== want.ex)
                    $display("%0t: clip_end_x exp %0d got %0d", $time, want.ex, got.ex);
                if (got.ed !== want.ed)
                    $display("%0t: clip_end_depth exp %0d got %0d", $time, want.ed, got.ed);
                if (got.t0 !== want.t0)
                    $display("%0t: tex_start exp %0d got %0d", $time, want.t0, got.t0);
                if (got.t1 !== want.t1)
                    $display("%0t: tex_end exp %0d got %0d", $time, want.t1, got.t1);
                if (got.fault !== want.fault)
                    $display("%0t: div_fault exp %0b got %0b", $time, want.fault, got.fault);
                if (got !== want)
                    error_count++;
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #40000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence.
    initial
    begin
        wall_row_t rows[$];
        wall_row_t row;
        clip_t     fault_clip;
        clip_t     none_clip;
        wall_t     w;
        rst_n       = 1'b0;
        seg_valid   = 1'b0;
        start_x     = '0;
        start_depth = '0;
        end_x       = '0;
        end_depth   = '0;
        tex_span    = '0;
        cfg_write   = 1'b0;
        cfg_index   = wsfc_pkg::REG_NEAR_DEPTH;
        cfg_data    = '0;
        error_count = 0;
        quiet_tail  = 1'b0;
        frustum_near_depth = wsfc_pkg::NEAR_DEPTH_RST;
        frustum_near_half  = wsfc_pkg::NEAR_HALF_WIDTH_RST;
        frustum_far_depth  = wsfc_pkg::FAR_DEPTH_RST;
        frustum_far_half   = wsfc_pkg::FAR_HALF_WIDTH_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        fault_clip = '0;
        fault_clip.fault = 1'b1;
        none_clip = '0;

        // Directed rows under the reset frustum. A segment wholly in front
        // whose ends share every coordinate has a zero texture divisor; a degenerate
        // point behind the near plane has zero edge divisors (parallel lines).
        row.has_known = 1'b1;
        row.known = fault_clip;
        row.wall = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0};
        rows.push_back(row);
        row.wall = '{32'sh0010_0000, 32'sh0020_0000, 32'sh0010_0000, 32'sh0020_0000, 31'd65536};
        rows.push_back(row);
        // A wall in front, drawn along depth: nothing clipped, texture 0 to span.
        row.known = '{32'sd0, 32'sh0002_0000, 32'sd0, 32'sh0004_0000,
                      32'sd0, 32'sh0001_0000, 1'b0};
        row.wall = '{32'sd0, 32'sh0002_0000, 32'sd0, 32'sh0004_0000, 31'd65536};
        rows.push_back(row);
        // The rest go through the predictor: extremes, both ends clipped,
        // one end clipped, lateral walls and full-scale spans.
        row.has_known = 1'b0;
        row.known = none_clip;
        row.wall = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF};
        rows.push_back(row);
        row.wall = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF};
        rows.push_back(row);
        row.wall = '{32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'd1};
        rows.push_back(row);
        row.wall = '{-32'sh0004_0000, -32'sh0001_0000, 32'sh0004_0000, 32'sh0008_0000, 31'd65536};
        rows.push_back(row);
        row.wall = '{32'sh0004_0000, 32'sh0008_0000, -32'sh0004_0000, -32'sh0001_0000, 31'h40_0000};
        rows.push_back(row);
        row.wall = '{-32'sh0008_0000, 32'sh0000_8000, 32'sh0008_0000, 32'sh0000_4000, 31'h10_0000};
        rows.push_back(row);
        row.wall = '{-32'sh0010_0000, 32'sh0003_0000, 32'sh0010_0000, 32'sh0003_0000, 31'h7FFF_FFFF};
        rows.push_back(row);
        row.wall = '{32'sh0001_0000, -32'sh0005_0000, 32'sh0003_0000, 32'sh0006_0000, 31'd12345};
        rows.push_back(row);
        row.wall = '{-32'sh0003_0000, 32'sh0006_0000, -32'sh0001_0000, -32'sh0005_0000, 31'd99999};
        rows.push_back(row);
        row.wall = '{32'sh5555_5555, 32'shAAAA_AAAA, 32'shAAAA_AAAA, 32'sh5555_5555, 31'h2AAA_AAAA};
        rows.push_back(row);
        row.wall = '{32'sd0, 32'sh0001_0000, 32'sd0, 32'sh0002_0000, 31'h5555_5555};
        rows.push_back(row);
        foreach (rows[i])
            send_wall(rows[i].wall, rows[i].has_known, rows[i].known);
        seg_valid <= 1'b0;
        drain_pipeline();

        // Random phases over several frustum settings, the extremes among them.
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: ;
                1: set_frustum(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
                2: set_frustum(31'd0, 31'd0, 31'd0, 31'd0);
                3: set_frustum(31'd32768, 31'd65536, 31'h0A00_0000, 31'h1400_0000);
                4: set_frustum(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom));
                default: set_frustum(wsfc_pkg::NEAR_DEPTH_RST, wsfc_pkg::NEAR_HALF_WIDTH_RST,
                                     wsfc_pkg::FAR_DEPTH_RST, wsfc_pkg::FAR_HALF_WIDTH_RST);
            endcase
            if (phase == 5)
                quiet_tail = 1'b1;
            for (int n = 0; n < 115; n++)
            begin
                w = rand_wall();
                send_wall(w, 1'b0, none_clip);
                // Once, hold the sender until everything in flight has come.
                if (phase == 0 && n == 50)
                begin
                    seg_valid <= 1'b0;
                    while (pending_clips.size() != 0)
                        @(negedge clk);
                end
            end
            seg_valid <= 1'b0;
            drain_pipeline();
        end

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
src/wsfc_pkg.sv
src/wsfc_div.sv
src/wall_segment_frustum_clip.sv
bench/tb_wall_segment_frustum_clip.sv
